/* rtl/svd_pkg.sv */
package svd_pkg;

	localparam int NUM_DIGITS     = 6;
	localparam int POS_W          = 3;
	localparam int CNT_W          = 14;
	localparam int BLINK_ON_TICKS = 5000;
	localparam int BLINK_WRAP     = 10000;
	localparam int VALUE_W        = 32;
	localparam int DP_W           = 6;
	localparam int REG_IDX_W      = 2;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SHOW_ZEROS = 2'd0,
		REG_BLINK_EN   = 2'd1,
		REG_DP_MASK    = 2'd2
	} reg_idx_t;

	typedef logic [7:0] seg_t;

	// segment codes for one decimal digit, bit 0 is segment a
	function automatic seg_t seg_of(input logic [3:0] digit);
		seg_t code;
		case (digit)
			4'd0: code = 8'h3f;
			4'd1: code = 8'h06;
			4'd2: code = 8'h5b;
			4'd3: code = 8'h4f;
			4'd4: code = 8'h66;
			4'd5: code = 8'h6d;
			4'd6: code = 8'h7d;
			4'd7: code = 8'h07;
			4'd8: code = 8'h7f;
			4'd9: code = 8'h6f;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

/* rtl/svd_blink.sv */
module svd_blink (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic blink_enable,
	output logic dark
);

	logic [svd_pkg::CNT_W-1:0] cnt_q;
	logic [svd_pkg::CNT_W-1:0] cnt_inc;
	logic [svd_pkg::CNT_W-1:0] cnt_next;
	logic                      dark_q;

	always_comb begin
		cnt_inc  = cnt_q + svd_pkg::CNT_W'(1);
		cnt_next = (cnt_inc > svd_pkg::CNT_W'(svd_pkg::BLINK_WRAP)) ?
			'0 : cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dark_q <= 1'b0;
		end else if (advance) begin
			cnt_q  <= cnt_next;
			dark_q <= blink_enable &&
				(cnt_next >= svd_pkg::CNT_W'(svd_pkg::BLINK_ON_TICKS));
		end
	end

	assign dark = dark_q;

endmodule

/* rtl/svd_digit.sv */
module svd_digit (
	input  logic [svd_pkg::VALUE_W-1:0] rest,
	input  logic                        blank,
	input  logic                        show_leading_zeros,
	input  logic                        point,
	output svd_pkg::seg_t               seg,
	output logic [svd_pkg::VALUE_W-1:0] quot,
	output logic                        blank_next
);

	// rest / 10 as a multiply by the rounded-up reciprocal 2^35 / 10
	logic [63:0] prod;
	logic [3:0]  rem;

	always_comb begin
		prod = {32'd0, rest} * 64'h0000_0000_CCCC_CCCD;
		quot = {3'd0, prod[63:35]};
		rem  = 4'(rest - (quot * 32'd10));
		seg  = blank ? {point, 7'd0} : (svd_pkg::seg_of(rem) | {point, 7'd0});
		blank_next = blank || (!show_leading_zeros && (quot == '0));
	end

endmodule

/* rtl/seven_segment_decimal_display.sv */
// Flow: an item's beat is taken into the input register and starts the scan counter once
// it is free; each scan word is then registered in the output register.
// Throughput: one scan word per cycle out of the scan counter while out_stall does not
// hold it; the next item starts on the cycle the sixth word is registered.
// Reset: clears the configuration registers, scan counter, stored digits (all dark), blink counter and all valids.
module seven_segment_decimal_display (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [svd_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [svd_pkg::DP_W-1:0]            wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [svd_pkg::VALUE_W-1:0]         value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [15:0]                         bus_word,
	output logic [svd_pkg::POS_W-1:0]           position,
	output logic                                last
);

	logic                        show_zeros_q;
	logic                        blink_en_q;
	logic [svd_pkg::DP_W-1:0]    dp_mask_q;

	logic                        valid_s1;
	logic                        opcode_s1;
	logic [svd_pkg::VALUE_W-1:0] value_s1;

	logic                        busy_q;
	logic [svd_pkg::POS_W-1:0]   idx_q;
	logic [svd_pkg::VALUE_W-1:0] rest_q;
	logic                        blank_q;
	logic                        load_q;
	svd_pkg::seg_t               digit_store_q [svd_pkg::NUM_DIGITS];

	logic                        out_valid_q;
	logic [15:0]                 bus_word_q;
	logic [svd_pkg::POS_W-1:0]   position_q;
	logic                        last_q;

	logic                        out_free;
	logic                        step;
	logic                        last_step;
	logic                        start;
	logic                        dark;
	logic                        point;
	logic [7:0]                  dp_ext;
	svd_pkg::seg_t               seg_new;
	svd_pkg::seg_t               seg_word;
	logic [7:0]                  sel;
	logic [svd_pkg::VALUE_W-1:0] quot;
	logic                        blank_next;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_zeros_q <= 1'b0;
			blink_en_q   <= 1'b0;
			dp_mask_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				svd_pkg::REG_SHOW_ZEROS: show_zeros_q <= wr_data[0];
				svd_pkg::REG_BLINK_EN:   blink_en_q   <= wr_data[0];
				svd_pkg::REG_DP_MASK:    dp_mask_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign step      = busy_q && out_free;
	assign last_step = (idx_q == svd_pkg::LAST_POS);
	assign start     = valid_s1 && (!busy_q || (step && last_step));
	assign in_stall  = valid_s1 && !start;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (start) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			value_s1  <= value;
		end
	end

	svd_blink u_blink (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (start),
		.blink_enable (blink_en_q),
		.dark         (dark)
	);

	assign dp_ext = {(8 - svd_pkg::DP_W)'(0), dp_mask_q};
	assign point  = dp_ext[idx_q];

	svd_digit u_digit (
		.rest               (rest_q),
		.blank              (blank_q),
		.show_leading_zeros (show_zeros_q),
		.point              (point),
		.seg                (seg_new),
		.quot               (quot),
		.blank_next         (blank_next)
	);

	// scan counter: one digit per beat, ones digit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			rest_q  <= '0;
			blank_q <= 1'b0;
			load_q  <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			rest_q  <= value_s1;
			blank_q <= 1'b0;
			load_q  <= (opcode_s1 == svd_pkg::OP_LOAD);
		end else if (step && last_step) begin
			busy_q <= 1'b0;
		end else if (step) begin
			idx_q   <= idx_q + svd_pkg::POS_W'(1);
			rest_q  <= quot;
			blank_q <= blank_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < svd_pkg::NUM_DIGITS; i++) begin
				digit_store_q[i] <= '0;
			end
		end else if (step && load_q) begin
			digit_store_q[idx_q] <= seg_new;
		end
	end

	always_comb begin
		seg_word = dark ? '0 : (load_q ? seg_new : digit_store_q[idx_q]);
		sel      = ~(8'd1 << (svd_pkg::LAST_POS - idx_q));
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			bus_word_q <= {seg_word, sel};
			position_q <= idx_q;
			last_q     <= last_step;
		end
	end

	assign out_valid = out_valid_q;
	assign bus_word  = bus_word_q;
	assign position  = position_q;
	assign last      = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= svd_pkg::LAST_POS)
		else $error("scan index beyond last digit");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && idx_q == '0)
		else $error("scan did not restart at the ones digit");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_step |=> out_valid_q && last_q && position_q == svd_pkg::LAST_POS)
		else $error("final scan word not flagged");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !step)
		else $error("stalled scan word overwritten");

endmodule
